>>> hw/rtl/nhps_pkg.sv
// Shared types and constants for the node histogram permutation sampler.
`default_nettype none

package nhps_pkg;

  localparam int OP_W       = 2;
  localparam int POS_W      = 5;
  localparam int VAL_W      = 5;
  localparam int RF_W       = 16;
  localparam int RF_HALF_W  = 8;
  localparam int LEN_W      = 6;
  localparam int EPS_W      = 16;
  localparam int EPS_FRAC_W = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int MIN_LEN    = 2;

  localparam logic [LEN_W-1:0] LEN_RESET = 6'd32;
  localparam logic [EPS_W-1:0] EPS_RESET = 16'd256;

  localparam logic [CFG_IDX_W-1:0] CFG_POSITIONS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_EPSILON   = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR   = 2'd0,
    OP_OBSERVE = 2'd1,
    OP_DRAW    = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OBS_WR,
    ST_SUM,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_PICK
  } state_t;

endpackage

`default_nettype wire

>>> hw/rtl/node_histogram_permutation_sampler_unit.sv
// Top level: request control, serial roulette-wheel draw and configuration registers.
// Clear and an out-of-range observe keep the unit idle; busy stays low for a clear and
// high for one cycle after an observe in range. A draw runs these steps after the cycle that
// took the request (n = active length): n summing steps on the row read at acceptance, two
// multiply steps, up to n selection steps and the output register, which shows the result.
// Synchronous reset invalidates every matrix row at once, so the matrix reads as zero with
// no clearing pass; the result strobe lasts one cycle and cannot be stalled.
`default_nettype none

module node_histogram_permutation_sampler_unit #(
  parameter int MAX_POSITIONS = 32,
  parameter int COUNT_BITS    = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [nhps_pkg::OP_W-1:0]       in_operation,
  input  wire logic [nhps_pkg::POS_W-1:0]      in_position,
  input  wire logic [nhps_pkg::VAL_W-1:0]      in_value,
  input  wire logic [nhps_pkg::RF_W-1:0]       in_random_fraction,
  output logic                                 out_valid,
  output logic [nhps_pkg::POS_W-1:0]           out_drawn_position,
  output logic [nhps_pkg::VAL_W-1:0]           out_drawn_value,
  output logic                                 out_permutation_done,
  input  wire logic                            cfg_we,
  input  wire logic [nhps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [nhps_pkg::CFG_DATA_W-1:0] cfg_data
);

  import nhps_pkg::*;

  localparam int RW    = $clog2(MAX_POSITIONS);
  localparam int LW    = $clog2(MAX_POSITIONS + 1);
  localparam int ROW_W = MAX_POSITIONS * COUNT_BITS;
  localparam int WW    = COUNT_BITS + EPS_FRAC_W + 1;
  localparam int TW    = WW + RW;
  localparam int PW    = TW + RF_W;
  localparam int XW    = LW + LEN_W;

  state_t                   state_r, state_nxt;
  logic [LEN_W-1:0]         len_r;
  logic [EPS_W-1:0]         eps_r;
  logic [MAX_POSITIONS-1:0] used_r, used_nxt;
  logic [LW-1:0]            np_r, np_nxt;
  logic [RW-1:0]            p_r, p_nxt;
  logic [RW-1:0]            col_r, col_nxt;
  logic [RW-1:0]            j_r, j_nxt;
  logic [RF_W-1:0]          rf_r, rf_nxt;
  logic [TW-1:0]            total_r, total_nxt;
  logic [TW-1:0]            partial_r, partial_nxt;
  logic [TW+RF_HALF_W-1:0]  lo_r, lo_nxt;
  logic [PW-1:0]            target_r, target_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [POS_W-1:0]         out_pos_r, out_pos_nxt;
  logic [VAL_W-1:0]         out_val_r, out_val_nxt;
  logic                     out_done_r, out_done_nxt;

  logic [LW-1:0]            n;
  logic                     clear_all;
  logic                     rd_en;
  logic [RW-1:0]            rd_row;
  logic [ROW_W-1:0]         rd_data;
  logic                     wr_en;
  logic [ROW_W-1:0]         wr_data;
  logic [COUNT_BITS-1:0]    cnt_sel;
  logic [COUNT_BITS-1:0]    obs_cnt;
  logic [WW-1:0]            weight;
  logic [TW-1:0]            partial_sum;
  logic                     last_j;
  logic                     hit;
  logic                     done;
  logic [RW-1:0]            chosen;
  logic [RF_HALF_W-1:0]     mul_b;
  logic [TW+RF_HALF_W-1:0]  prod;

  nhps_row_mem #(
    .MAX_POSITIONS(MAX_POSITIONS),
    .RW           (RW),
    .ROW_W        (ROW_W)
  ) u_row_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .clear_all(clear_all),
    .rd_en    (rd_en),
    .rd_row   (rd_row),
    .rd_data  (rd_data),
    .wr_en    (wr_en),
    .wr_row   (p_r),
    .wr_data  (wr_data)
  );

  always_comb begin
    if (XW'(len_r) < XW'(MIN_LEN)) begin
      n = LW'(MIN_LEN);
    end else if (XW'(len_r) > XW'(MAX_POSITIONS)) begin
      n = LW'(MAX_POSITIONS);
    end else begin
      n = LW'(len_r);
    end
  end

  assign cnt_sel     = rd_data[j_r*COUNT_BITS +: COUNT_BITS];
  assign obs_cnt     = rd_data[col_r*COUNT_BITS +: COUNT_BITS];
  assign weight      = (WW'(cnt_sel) << EPS_FRAC_W) + WW'(eps_r);
  assign partial_sum = partial_r + (used_r[j_r] ? '0 : TW'(weight));
  assign last_j      = (XW'(j_r) + XW'(1)) == XW'(n);
  assign hit         = !used_r[j_r] && ((PW'(partial_sum) << RF_W) >= target_r);
  assign chosen      = hit ? j_r : '0;
  assign done        = (XW'(p_r) + XW'(1)) >= XW'(n);
  assign mul_b       = (state_r == ST_MUL_LO) ? rf_r[RF_HALF_W-1:0] : rf_r[RF_W-1:RF_HALF_W];
  assign prod        = (TW+RF_HALF_W)'(total_r) * (TW+RF_HALF_W)'(mul_b);

  always_comb begin
    wr_data = rd_data;
    if (obs_cnt != '1) begin
      wr_data[col_r*COUNT_BITS +: COUNT_BITS] = obs_cnt + COUNT_BITS'(1);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    used_nxt      = used_r;
    np_nxt        = np_r;
    p_nxt         = p_r;
    col_nxt       = col_r;
    j_nxt         = j_r;
    rf_nxt        = rf_r;
    total_nxt     = total_r;
    partial_nxt   = partial_r;
    lo_nxt        = lo_r;
    target_nxt    = target_r;
    out_valid_nxt = 1'b0;
    out_pos_nxt   = out_pos_r;
    out_val_nxt   = out_val_r;
    out_done_nxt  = out_done_r;
    clear_all     = 1'b0;
    rd_en         = 1'b0;
    rd_row        = RW'(in_position);
    wr_en         = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_operation == OP_CLEAR) begin
            clear_all = 1'b1;
            used_nxt  = '0;
            np_nxt    = '0;
          end else if (in_operation == OP_OBSERVE) begin
            if ((XW'(in_position) < XW'(n)) && (XW'(in_value) < XW'(n))) begin
              rd_en     = 1'b1;
              p_nxt     = RW'(in_position);
              col_nxt   = RW'(in_value);
              state_nxt = ST_OBS_WR;
            end
          end else if (in_operation == OP_DRAW) begin
            if (XW'(np_r) >= XW'(n)) begin
              p_nxt    = '0;
              used_nxt = '0;
            end else begin
              p_nxt = RW'(np_r);
            end
            rd_en       = 1'b1;
            rd_row      = p_nxt;
            rf_nxt      = in_random_fraction;
            j_nxt       = '0;
            total_nxt   = '0;
            partial_nxt = '0;
            state_nxt   = ST_SUM;
          end
        end
      end
      ST_OBS_WR: begin
        wr_en     = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_SUM: begin
        partial_nxt = partial_sum;
        total_nxt   = partial_sum;
        if (last_j) begin
          state_nxt = ST_MUL_LO;
        end else begin
          j_nxt = j_r + RW'(1);
        end
      end
      ST_MUL_LO: begin
        lo_nxt    = prod;
        state_nxt = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        target_nxt  = PW'(lo_r) + (PW'(prod) << RF_HALF_W);
        j_nxt       = '0;
        partial_nxt = '0;
        state_nxt   = ST_PICK;
      end
      ST_PICK: begin
        partial_nxt = partial_sum;
        if (hit || last_j) begin
          out_valid_nxt    = 1'b1;
          out_pos_nxt      = POS_W'(p_r);
          out_val_nxt      = VAL_W'(chosen);
          out_done_nxt     = done;
          used_nxt[chosen] = 1'b1;
          if (done) begin
            used_nxt = '0;
            np_nxt   = '0;
          end else begin
            np_nxt = LW'(p_r) + LW'(1);
          end
          state_nxt = ST_IDLE;
        end else begin
          j_nxt = j_r + RW'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= '0;
      np_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      np_r        <= np_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= LEN_RESET;
      eps_r <= EPS_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_POSITIONS) begin
        len_r <= cfg_data[LEN_W-1:0];
      end else if (cfg_index == CFG_EPSILON) begin
        eps_r <= cfg_data[EPS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    p_r        <= p_nxt;
    col_r      <= col_nxt;
    j_r        <= j_nxt;
    rf_r       <= rf_nxt;
    total_r    <= total_nxt;
    partial_r  <= partial_nxt;
    lo_r       <= lo_nxt;
    target_r   <= target_nxt;
    out_pos_r  <= out_pos_nxt;
    out_val_r  <= out_val_nxt;
    out_done_r <= out_done_nxt;
  end

  assign busy                 = (state_r != ST_IDLE);
  assign out_valid            = out_valid_r;
  assign out_drawn_position   = out_pos_r;
  assign out_drawn_value      = out_val_r;
  assign out_permutation_done = out_done_r;

endmodule

`default_nettype wire

>>> hw/rtl/nhps_row_mem.sv
// Count matrix storage: one row of counts per position, with per-row valid bits.
`default_nettype none

module nhps_row_mem #(
  parameter int MAX_POSITIONS = 32,
  parameter int RW            = 5,
  parameter int ROW_W         = 512
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             clear_all,
  input  wire logic             rd_en,
  input  wire logic [RW-1:0]    rd_row,
  output logic      [ROW_W-1:0] rd_data,
  input  wire logic             wr_en,
  input  wire logic [RW-1:0]    wr_row,
  input  wire logic [ROW_W-1:0] wr_data
);

  logic [ROW_W-1:0]         mem [MAX_POSITIONS];
  logic [MAX_POSITIONS-1:0] row_valid_r;
  logic [ROW_W-1:0]         rd_data_r;
  logic                     rd_valid_r;

  // A row that has not been written since the last clear reads as all zero.
  always_ff @(posedge clk) begin
    if (!rst_n || clear_all) begin
      row_valid_r <= '0;
    end else if (wr_en) begin
      row_valid_r[wr_row] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_row] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r  <= mem[rd_row];
      rd_valid_r <= row_valid_r[rd_row];
    end
  end

  assign rd_data = rd_valid_r ? rd_data_r : '0;

endmodule

`default_nettype wire

>>> dv/node_histogram_permutation_sampler_unit_test.sv
// Self-checking testbench for the node histogram permutation sampler, with a roulette-wheel scoreboard.
module node_histogram_permutation_sampler_unit_test;
  import nhps_pkg::*;

  localparam int MAX_POSITIONS = 32;
  localparam int COUNT_BITS = 8;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 2 * MAX_POSITIONS + 12;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int PHASES = 12;
  localparam int PHASE_ITEMS = 120;
  localparam int SATURATE_ITEMS = (1 << COUNT_BITS) + 4;

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] value;
    logic             done;
  } draw_t;

  class permutation_scoreboard;
    bit [COUNT_BITS-1:0] counts [MAX_POSITIONS*MAX_POSITIONS];
    bit [MAX_POSITIONS-1:0] used;
    int next_position;
    bit [LEN_W-1:0] positions_in_use;
    bit [EPS_W-1:0] epsilon;
    draw_t expected_draws[$];
    int errors;

    function new();
      foreach (counts[i]) counts[i] = '0;
      used = '0;
      next_position = 0;
      positions_in_use = LEN_RESET;
      epsilon = EPS_RESET;
      errors = 0;
    endfunction

    function int active_length();
      if (positions_in_use < MIN_LEN) return MIN_LEN;
      if (positions_in_use > MAX_POSITIONS) return MAX_POSITIONS;
      return int'(positions_in_use);
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      if (index == CFG_POSITIONS) positions_in_use = data[LEN_W-1:0];
      else epsilon = data[EPS_W-1:0];
    endfunction

    function u64_t weight(int p, int j);
      return (u64_t'(counts[p*MAX_POSITIONS+j]) << EPS_FRAC_W) + u64_t'(epsilon);
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                               logic [VAL_W-1:0] val, logic [RF_W-1:0] rf);
      int n;
      int p;
      int idx;
      int chosen;
      u64_t total;
      u64_t partial;
      u64_t target;
      draw_t d;
      n = active_length();
      case (op)
        OP_CLEAR: begin
          foreach (counts[i]) counts[i] = '0;
          used = '0;
          next_position = 0;
        end
        OP_OBSERVE: begin
          idx = pos * MAX_POSITIONS + val;
          if (pos < n && val < n && counts[idx] != '1) counts[idx]++;
        end
        OP_DRAW: begin
          if (next_position >= n) begin
            used = '0;
            next_position = 0;
          end
          p = next_position;
          total = 0;
          partial = 0;
          chosen = 0;
          for (int j = 0; j < n; j++) if (!used[j]) total += weight(p, j);
          target = total * u64_t'(rf);
          for (int j = 0; j < n; j++) begin
            if (!used[j]) begin
              partial += weight(p, j);
              if ((partial << RF_W) >= target) begin
                chosen = j;
                break;
              end
            end
          end
          used[chosen] = 1'b1;
          d.position = p[POS_W-1:0];
          d.value = chosen[VAL_W-1:0];
          d.done = (p + 1 >= n);
          if (d.done) begin
            used = '0;
            next_position = 0;
          end else begin
            next_position = p + 1;
          end
          expected_draws.push_back(d);
        end
        default: ;
      endcase
    endfunction

    function void check_draw(logic [POS_W-1:0] position, logic [VAL_W-1:0] value, logic done);
      draw_t want;
      if (expected_draws.size() == 0) begin
        errors++;
        $display("%0t unexpected draw: expected none, actual position %0d value %0d done %0d",
                 $time, position, value, done);
        return;
      end
      want = expected_draws.pop_front();
      if (position !== want.position) begin
        errors++;
        $display("%0t drawn_position: expected %0d, actual %0d", $time, want.position, position);
      end
      if (value !== want.value) begin
        errors++;
        $display("%0t drawn_value: expected %0d, actual %0d", $time, want.value, value);
      end
      if (done !== want.done) begin
        errors++;
        $display("%0t permutation_done: expected %0d, actual %0d", $time, want.done, done);
      end
    endfunction

    function int pending();
      return expected_draws.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [OP_W-1:0] in_operation = '0;
  logic [POS_W-1:0] in_position = '0;
  logic [VAL_W-1:0] in_value = '0;
  logic [RF_W-1:0] in_random_fraction = '0;
  logic out_valid;
  logic [POS_W-1:0] out_drawn_position;
  logic [VAL_W-1:0] out_drawn_value;
  logic out_permutation_done;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  permutation_scoreboard sb = new();
  int cycle_count = 0;
  int burst_left = 4;
  bit steady = 1'b0;
  bit sending = 1'b0;

  int phase_len [PHASES] = '{32, 2, 0, 63, 17, 1, 33, 32, -1, 5, 32, -1};
  int phase_eps [PHASES] = '{256, 0, 65535, 1, -1, 0, 255, 65535, -1, 256, 0, -1};

  node_histogram_permutation_sampler_unit #(
    .MAX_POSITIONS(MAX_POSITIONS),
    .COUNT_BITS   (COUNT_BITS)
  ) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_operation        (in_operation),
    .in_position         (in_position),
    .in_value            (in_value),
    .in_random_fraction  (in_random_fraction),
    .out_valid           (out_valid),
    .out_drawn_position  (out_drawn_position),
    .out_drawn_value     (out_drawn_value),
    .out_permutation_done(out_permutation_done),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL node_histogram_permutation_sampler_unit");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_draw(out_drawn_position, out_drawn_value,
                                          out_permutation_done);
  end

  function automatic logic [RF_W-1:0] rand_fraction();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return RF_W'($urandom_range(0, 65535));
  endfunction

  task automatic lower_start();
    if (sending) begin
      start <= 1'b0;
      sending = 1'b0;
    end
  endtask

  task automatic send_item(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                           input logic [VAL_W-1:0] val, input logic [RF_W-1:0] rf);
    in_operation <= op;
    in_position <= pos;
    in_value <= val;
    in_random_fraction <= rf;
    if (!sending) begin
      start <= 1'b1;
      sending = 1'b1;
    end
    do @(posedge clk); while (busy);
    sb.note_request(op, pos, val, rf);
    if (!steady) begin
      if (burst_left == 0) begin
        lower_start();
        repeat ($urandom_range(1, 12)) @(posedge clk);
        burst_left = $urandom_range(1, 16);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic settle();
    lower_start();
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    @(posedge clk);
    sb.write_register(index, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int n;
    int roll;
    int counted;
    int len;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(OP_UNUSED, '1, '1, '1);
    send_item(OP_DRAW, '0, '0, '0);
    send_item(OP_DRAW, '1, '1, '1);
    send_item(OP_OBSERVE, 5'd31, 5'd31, '0);
    send_item(OP_OBSERVE, 5'd0, 5'd0, '1);
    send_item(OP_OBSERVE, 5'd2, 5'd31, '0);
    send_item(OP_OBSERVE, 5'd31, 5'd0, '0);
    send_item(OP_DRAW, '0, '0, '1);
    settle();
    program_register(CFG_POSITIONS, 16'd2);
    program_register(CFG_EPSILON, 16'd0);
    send_item(OP_DRAW, '0, '0, 16'h8000);
    send_item(OP_CLEAR, '1, '1, '1);
    send_item(OP_DRAW, '0, '0, '1);
    send_item(OP_DRAW, '0, '0, '0);
    send_item(OP_OBSERVE, 5'd0, 5'd1, '0);
    send_item(OP_OBSERVE, 5'd1, 5'd0, '0);
    send_item(OP_OBSERVE, 5'd5, 5'd0, '0);
    send_item(OP_OBSERVE, 5'd0, 5'd5, '0);
    send_item(OP_DRAW, '0, '0, 16'h8000);
    send_item(OP_DRAW, '0, '0, '1);
    settle();
    program_register(CFG_EPSILON, 16'hFFFF);
    send_item(OP_DRAW, '0, '0, '0);
    send_item(OP_DRAW, '0, '0, '1);

    // Drive one cell well past its saturation point, then draw a whole permutation.
    settle();
    program_register(CFG_POSITIONS, 16'd32);
    program_register(CFG_EPSILON, CFG_DATA_W'($urandom_range(0, 65535)));
    send_item(OP_CLEAR, '0, '0, '0);
    pos = POS_W'($urandom);
    val = VAL_W'($urandom);
    steady = 1'b1;
    for (int k = 0; k < SATURATE_ITEMS; k++) send_item(OP_OBSERVE, pos, val, RF_W'($urandom));
    for (int k = 0; k < 8; k++) send_item(OP_OBSERVE, pos, val ^ 5'd1, RF_W'($urandom));
    steady = 1'b0;
    for (int k = 0; k < MAX_POSITIONS; k++)
      send_item(OP_DRAW, POS_W'($urandom), VAL_W'($urandom), rand_fraction());

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      len = (phase_len[ph] < 0) ? $urandom_range(0, 63) : phase_len[ph];
      program_register(CFG_POSITIONS, CFG_DATA_W'(($urandom_range(0, 1023) << LEN_W) | len));
      program_register(CFG_EPSILON,
                       CFG_DATA_W'((phase_eps[ph] < 0) ? $urandom_range(0, 65535)
                                                       : phase_eps[ph]));
      steady = (ph == 3 || ph == 8);
      if (phase_eps[ph] == 0 || $urandom_range(0, 2) == 0)
        send_item(OP_CLEAR, POS_W'($urandom), VAL_W'($urandom), rand_fraction());
      n = sb.active_length();
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
          send_item(OP_CLEAR, POS_W'($urandom), VAL_W'($urandom), RF_W'($urandom));
          counted++;
        end else if (roll < 6) begin
          send_item(OP_UNUSED, POS_W'($urandom), VAL_W'($urandom), RF_W'($urandom));
        end else if (roll < 50) begin
          if ($urandom_range(0, 9) != 0) begin
            pos = POS_W'($urandom_range(0, n - 1));
            val = VAL_W'($urandom_range(0, 1) ? (pos * 5 + $urandom_range(0, 2)) % n
                                              : $urandom_range(0, n - 1));
          end else begin
            pos = POS_W'($urandom);
            val = VAL_W'($urandom);
          end
          send_item(OP_OBSERVE, pos, val, RF_W'($urandom));
          if (pos < n && val < n) counted++;
        end else begin
          send_item(OP_DRAW, POS_W'($urandom), VAL_W'($urandom), rand_fraction());
          counted++;
        end
      end
      steady = 1'b0;
    end

    settle();
    if (sb.errors == 0) $display("PASS node_histogram_permutation_sampler_unit");
    else $display("FAIL node_histogram_permutation_sampler_unit");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/nhps_pkg.sv
hw/rtl/nhps_row_mem.sv
hw/rtl/node_histogram_permutation_sampler_unit.sv
dv/node_histogram_permutation_sampler_unit_test.sv
